// ===== rtl/core/lcs_pkg.sv =====
// ----------------------------------------------------------------------------
// lcs_pkg
// Shared types for the longest common substring unit: request and result
// payloads, controller states and the controller/datapath command and status.
// ----------------------------------------------------------------------------
package lcs_pkg;

  // Function codes of a request
  localparam logic FUNC_FIRST  = 1'b0;
  localparam logic FUNC_SECOND = 1'b1;

  typedef struct packed {
    logic       func;
    logic [7:0] in_byte;
    logic       last;
  } lcs_req_t;

  typedef struct packed {
    logic [6:0] match_length;
    logic [5:0] start_in_first;
    logic [9:0] start_in_second;
  } lcs_res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_DRAIN,
    ST_FINISH
  } lcs_state_t;

  // Controller to datapath
  typedef struct packed {
    logic first_write;  // store one first-string byte
    logic take_second;  // latch a second-string byte, rewind the sweep
    logic issue;        // read one cell and advance the sweep index
    logic finish;       // close the second-string byte, emit on last
  } lcs_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic sweep_needed; // cells exist and the second string is not full
    logic issue_last;   // sweep index is at the last stored byte
  } lcs_sts_t;

endpackage

// ===== rtl/core/lcs_ctrl.sv =====
// ----------------------------------------------------------------------------
// lcs_ctrl
// Sequencer of the unit: takes requests, walks the cell sweep for each
// second-string byte that needs one and closes every byte with a finish step.
// ----------------------------------------------------------------------------
module lcs_ctrl
  import lcs_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  logic     func,
  input  lcs_sts_t sts,
  output lcs_cmd_t cmd,
  output logic     busy
);

  lcs_state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    unique case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          if (func == FUNC_FIRST) begin
            cmd.first_write = 1'b1;
          end else begin
            cmd.take_second = 1'b1;
            state_next = sts.sweep_needed ? ST_SWEEP : ST_FINISH;
          end
        end
      end
      ST_SWEEP: begin
        cmd.issue = 1'b1;
        if (sts.issue_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        cmd.finish = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/lcs_datapath.sv =====
// ----------------------------------------------------------------------------
// lcs_datapath
// First-string store, run-length memory with fill count, one shared cell
// update unit and the best-match tracker with its result register.
// ----------------------------------------------------------------------------
module lcs_datapath
  import lcs_pkg::*;
#(
  parameter int MAX_FIRST  = 64,
  parameter int MAX_SECOND = 1024
) (
  input  logic     clk,
  input  logic     rst,
  input  lcs_req_t req,
  input  lcs_cmd_t cmd,
  output lcs_sts_t sts,
  output lcs_res_t result,
  output logic     result_valid
);

  localparam int RW = $clog2(MAX_FIRST + 1);                     // run length, count
  localparam int IW = (MAX_FIRST > 1) ? $clog2(MAX_FIRST) : 1;   // store index
  localparam int CW = $clog2(MAX_SECOND + 1);                    // second count
  localparam int SW = (MAX_SECOND > 1) ? $clog2(MAX_SECOND) : 1; // second start
  localparam int AW = ((RW > CW) ? RW : CW) + 1;
  localparam int EW = 32;

  logic [7:0]    store_mem [MAX_FIRST];
  logic [RW-1:0] run_mem   [MAX_FIRST];

  logic [RW-1:0] first_count;
  logic          first_closed;
  logic [CW-1:0] second_count;
  logic [RW-1:0] run_fill;
  logic [RW-1:0] best_length;
  logic [IW-1:0] best_s1;
  logic [SW-1:0] best_s2;

  logic [7:0]    byte_q;
  logic          last_q;
  logic [IW-1:0] idx;
  logic          proc_valid;
  logic [IW-1:0] proc_idx;
  logic [7:0]    store_rd;
  logic [RW-1:0] run_rd;
  logic          run_rd_ok;
  logic [RW-1:0] left_old;

  logic [RW-1:0] fc_base;
  logic          fc_room;
  logic [RW-1:0] run_old;
  logic [RW-1:0] now;
  logic [RW-1:0] s1_full;
  logic [AW-1:0] s2_full;
  logic [IW-1:0] s1;
  logic [SW-1:0] s2;
  logic          better;
  logic          second_room;
  logic [EW-1:0] len_ext;
  logic [EW-1:0] s1_ext;
  logic [EW-1:0] s2_ext;

  // Status to the controller
  assign second_room      = second_count < CW'(MAX_SECOND);
  assign sts.sweep_needed = (first_count != '0) && second_room;
  assign sts.issue_last   = (RW'(idx) + RW'(1)) == first_count;

  // First-string write position: a closed string restarts at offset zero
  assign fc_base = first_closed ? '0 : first_count;
  assign fc_room = fc_base < RW'(MAX_FIRST);

  // Cell update: entries beyond the fill count read as zero
  assign run_old = run_rd_ok ? run_rd : '0;
  assign now     = (store_rd == byte_q) ? (left_old + RW'(1)) : '0;
  assign s1_full = RW'(proc_idx) + RW'(1) - now;
  assign s2_full = AW'(second_count) + AW'(1) - AW'(now);
  assign s1      = s1_full[IW-1:0];
  assign s2      = s2_full[SW-1:0];
  assign better  = (now != '0) &&
                   ((now > best_length) ||
                    ((now == best_length) &&
                     ((s1 < best_s1) || ((s1 == best_s1) && (s2 < best_s2)))));

  assign len_ext = EW'(best_length);
  assign s1_ext  = EW'(best_s1);
  assign s2_ext  = EW'(best_s2);

  // First-string store
  always_ff @(posedge clk) begin
    if (cmd.first_write && fc_room) begin
      store_mem[fc_base[IW-1:0]] <= req.in_byte;
    end
    if (cmd.issue) begin
      store_rd <= store_mem[idx];
    end
  end

  // Run-length memory
  always_ff @(posedge clk) begin
    if (proc_valid) begin
      run_mem[proc_idx] <= now;
    end
    if (cmd.issue) begin
      run_rd    <= run_mem[idx];
      run_rd_ok <= RW'(idx) < run_fill;
    end
  end

  // Sweep pipeline registers
  always_ff @(posedge clk) begin
    if (cmd.take_second) begin
      byte_q   <= req.in_byte;
      last_q   <= req.last;
      idx      <= '0;
      left_old <= '0;
    end
    if (cmd.issue) begin
      idx      <= idx + IW'(1);
      proc_idx <= idx;
    end
    if (proc_valid) begin
      left_old <= run_old;
    end
  end

  // Counters, best match and result
  always_ff @(posedge clk) begin
    if (rst) begin
      first_count  <= '0;
      first_closed <= 1'b0;
      second_count <= '0;
      run_fill     <= '0;
      best_length  <= '0;
      best_s1      <= '0;
      best_s2      <= '0;
      proc_valid   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      proc_valid   <= cmd.issue;

      // Load a first-string byte; a restart or a last mark drops the pass
      if (cmd.first_write) begin
        first_count  <= fc_room ? (fc_base + RW'(1)) : fc_base;
        first_closed <= req.last;
        if (first_closed || req.last) begin
          second_count <= '0;
          run_fill     <= '0;
          best_length  <= '0;
          best_s1      <= '0;
          best_s2      <= '0;
        end
      end

      // Keep the best run of the sweep
      if (proc_valid && better) begin
        best_length <= now;
        best_s1     <= s1;
        best_s2     <= s2;
      end

      // Close the byte; on last emit and drop the pass
      if (cmd.finish) begin
        if (second_room) begin
          second_count <= second_count + CW'(1);
        end
        if (sts.sweep_needed) begin
          run_fill <= first_count;
        end
        if (last_q) begin
          result.match_length    <= len_ext[6:0];
          result.start_in_first  <= s1_ext[5:0];
          result.start_in_second <= s2_ext[9:0];
          result_valid           <= 1'b1;
          second_count           <= '0;
          run_fill               <= '0;
          best_length            <= '0;
          best_s1                <= '0;
          best_s2                <= '0;
        end
      end
    end
  end

  // Checks
  a_result_after_finish : assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(cmd.finish && last_q))
    else $error("result strobe without a finishing last byte");

  a_proc_follows_issue : assert property (@(posedge clk) disable iff (rst)
    proc_valid |-> $past(cmd.issue))
    else $error("cell update without a preceding read");

  a_issue_has_cells : assert property (@(posedge clk) disable iff (rst)
    cmd.issue |-> (first_count != '0))
    else $error("sweep read with an empty first string");

  a_best_bounded : assert property (@(posedge clk) disable iff (rst)
    1'b1 |-> ((best_length <= first_count) && (run_fill <= first_count)))
    else $error("best length or fill count beyond the stored bytes");

endmodule

// ===== rtl/core/longest_common_substring_unit.sv =====
// ----------------------------------------------------------------------------
// longest_common_substring_unit
// Longest common contiguous substring of two byte strings.
// ----------------------------------------------------------------------------
// A request is taken on a clock edge with start high and busy low. A byte of
// the first string is stored on the edge that takes it and busy stays low. A
// byte of the second string sweeps the stored bytes through one shared cell
// update unit, one stored byte a cycle out of the store and run-length
// memories, then passes a drain and a finish step; busy stays high from the
// request until the finish step is done, and through the finish step alone
// when there are no stored bytes or the second string is already full. The
// request that carries the last byte of the second string yields one result,
// shown with result_valid for exactly one cycle right after busy falls; the
// receiver must take it then. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module longest_common_substring_unit
  import lcs_pkg::*;
#(
  parameter int MAX_FIRST  = 64,
  parameter int MAX_SECOND = 1024
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  lcs_req_t request,
  output logic     busy,
  output lcs_res_t result,
  output logic     result_valid
);

  lcs_cmd_t cmd;
  lcs_sts_t sts;

  lcs_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .func  (request.func),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  lcs_datapath #(
    .MAX_FIRST  (MAX_FIRST),
    .MAX_SECOND (MAX_SECOND)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .req          (request),
    .cmd          (cmd),
    .sts          (sts),
    .result       (result),
    .result_valid (result_valid)
  );

endmodule

// ===== test/lcs_result_checker.sv =====
// ----------------------------------------------------------------------------
// lcs_result_checker
// Watches the request and result channels of the longest common substring
// unit, keeps its own copy of the string state, works out the result of each
// accepted request and compares every result field by field.
// ----------------------------------------------------------------------------
module lcs_result_checker
  import lcs_pkg::*;
#(
  parameter int MAX_FIRST  = 64,
  parameter int MAX_SECOND = 1024
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  lcs_req_t request,
  input  logic     busy,
  input  lcs_res_t result,
  input  logic     result_valid,
  output int       failures,
  output int       pending,
  output int       checked
);

  // Shadow copy of the string state
  logic [7:0] first_bytes [MAX_FIRST];
  logic [6:0] run_len [MAX_FIRST];
  logic [6:0] first_len;
  logic [10:0] second_len;
  logic [6:0] best_len;
  logic [5:0] best_first;
  logic [9:0] best_second;
  logic first_done;

  lcs_res_t expected_matches [$];
  int fail_cnt = 0;
  int check_cnt = 0;

  // Drop all runs and the best match of the current second string
  function automatic void clear_second_pass();
    for (int i = 0; i < MAX_FIRST; i++) run_len[i] = '0;
    second_len = '0;
    best_len = '0;
    best_first = '0;
    best_second = '0;
  endfunction

  // Advance every run by one second-string byte and track the best match
  function automatic void sweep_second_byte(input logic [7:0] b);
    int left_old;
    int old_run;
    int now_run;
    int s1;
    int s2;
    left_old = 0;
    for (int i = 0; i < MAX_FIRST; i++) begin
      if (i < int'(first_len)) begin
        old_run = int'(run_len[i]);
        now_run = (first_bytes[i] == b) ? left_old + 1 : 0;
        run_len[i] = now_run[6:0];
        left_old = old_run;
        if (now_run != 0) begin
          s1 = i + 1 - now_run;
          s2 = int'(second_len) + 1 - now_run;
          // Longer wins; on a tie the smaller first start, then second start
          if (now_run > int'(best_len) ||
              (now_run == int'(best_len) &&
               (s1 < int'(best_first) ||
                (s1 == int'(best_first) && s2 < int'(best_second))))) begin
            best_len = now_run[6:0];
            best_first = s1[5:0];
            best_second = s2[9:0];
          end
        end
      end
    end
    second_len = second_len + 11'd1;
  endfunction

  // Apply one accepted request; return 1 when it produces a result
  function automatic logic predict_match(input lcs_req_t r, output lcs_res_t res);
    res = '0;
    if (r.func == FUNC_FIRST) begin
      if (first_done) begin
        first_len = '0;
        first_done = 1'b0;
        clear_second_pass();
      end
      if (int'(first_len) < MAX_FIRST) begin
        first_bytes[first_len[5:0]] = r.in_byte;
        first_len = first_len + 7'd1;
      end
      if (r.last) begin
        first_done = 1'b1;
        clear_second_pass();
      end
      return 1'b0;
    end
    if (int'(second_len) < MAX_SECOND) sweep_second_byte(r.in_byte);
    if (!r.last) return 1'b0;
    res.match_length = best_len;
    res.start_in_first = best_first;
    res.start_in_second = best_second;
    clear_second_pass();
    return 1'b1;
  endfunction

  // Compare results first, then take the request of the same edge
  always @(posedge clk) begin : watch
    lcs_res_t want;
    lcs_res_t predicted;
    logic produces;
    if (rst) begin
      for (int i = 0; i < MAX_FIRST; i++) first_bytes[i] = '0;
      first_len = '0;
      first_done = 1'b0;
      clear_second_pass();
      expected_matches.delete();
    end else begin
      if (result_valid) begin
        if (expected_matches.size() == 0) begin
          $error("result with no request waiting: length %0d first %0d second %0d",
                 result.match_length, result.start_in_first, result.start_in_second);
          fail_cnt++;
        end else begin
          want = expected_matches.pop_front();
          check_cnt++;
          if (result.match_length !== want.match_length) begin
            $error("match_length: expected %0d, got %0d",
                   want.match_length, result.match_length);
            fail_cnt++;
          end
          if (result.start_in_first !== want.start_in_first) begin
            $error("start_in_first: expected %0d, got %0d",
                   want.start_in_first, result.start_in_first);
            fail_cnt++;
          end
          if (result.start_in_second !== want.start_in_second) begin
            $error("start_in_second: expected %0d, got %0d",
                   want.start_in_second, result.start_in_second);
            fail_cnt++;
          end
        end
      end
      if (start && !busy) begin
        produces = predict_match(request, predicted);
        if (produces) expected_matches.push_back(predicted);
      end
    end
    failures <= fail_cnt;
    pending <= expected_matches.size();
    checked <= check_cnt;
  end

endmodule

// ===== test/tb_longest_common_substring_unit.sv =====
// ----------------------------------------------------------------------------
// tb_longest_common_substring_unit
// Drives first and second strings into the longest common substring unit
// with random spacing: a directed opening, then mostly well-formed string
// pairs with random content, some loose requests and one overlong second
// string. A checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_longest_common_substring_unit;
  import lcs_pkg::*;

  localparam int MAX_FIRST = 64;
  localparam int MAX_SECOND = 1024;
  localparam int ITEM_TARGET = 1350;
  localparam int RESULT_TARGET = 48;
  localparam int SETTLE_CYCLES = MAX_FIRST + 16;
  localparam int CYCLE_LIMIT = 1000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  lcs_req_t request = '0;
  logic busy;
  lcs_res_t result;
  logic result_valid;

  int failures;
  int pending;
  int checked;

  int cycle_count = 0;
  int items_sent = 0;
  int results_due = 0;
  logic burst = 1'b0;
  logic [7:0] symbols [4];
  int alpha = 0;

  longest_common_substring_unit #(
    .MAX_FIRST (MAX_FIRST),
    .MAX_SECOND(MAX_SECOND)
  ) DUT (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .request     (request),
    .busy        (busy),
    .result      (result),
    .result_valid(result_valid)
  );

  lcs_result_checker #(
    .MAX_FIRST (MAX_FIRST),
    .MAX_SECOND(MAX_SECOND)
  ) checker_i (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .request     (request),
    .busy        (busy),
    .result      (result),
    .result_valid(result_valid),
    .failures    (failures),
    .pending     (pending),
    .checked     (checked)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("longest_common_substring_unit: mismatch");
      $finish;
    end
  end

  // Offer one request, hold it until taken, then idle for a random spell
  task automatic push_request(input logic f, input logic [7:0] b, input logic l);
    lcs_req_t r;
    int idle;
    r.func = f;
    r.in_byte = b;
    r.last = l;
    start <= 1'b1;
    request <= r;
    do @(posedge clk); while (busy);
    items_sent++;
    if (f == FUNC_SECOND && l) results_due++;
    idle = burst ? 0 : $urandom_range(0, 19);
    if (idle != 0) begin
      start <= 1'b0;
      repeat (idle) @(posedge clk);
    end
  endtask

  task automatic send_text(input logic f, input logic [7:0] text[$]);
    for (int i = 0; i < text.size(); i++) push_request(f, text[i], i == text.size() - 1);
  endtask

  // Hold off until every outstanding result has come back
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] draw_char();
    if (alpha == 0) return 8'($urandom_range(0, 255));
    return symbols[$urandom_range(0, alpha - 1)];
  endfunction

  initial begin
    logic [7:0] first_text [$];
    logic [7:0] second_text [$];
    logic [7:0] base;
    int base_items;
    int base_results;
    int flen;
    int roll;
    int spot;
    logic overflow_done;
    logic midway_done;

    overflow_done = 1'b0;
    midway_done = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed opening
    // empty first string: no match
    push_request(FUNC_SECOND, 8'h00, 1'b1);
    // second string against a first string still open
    push_request(FUNC_FIRST, 8'h00, 1'b0);
    push_request(FUNC_FIRST, 8'hFF, 1'b0);
    push_request(FUNC_SECOND, 8'hFF, 1'b1);
    // close the first string, then a byte with no common character
    push_request(FUNC_FIRST, 8'h00, 1'b1);
    push_request(FUNC_SECOND, 8'h5A, 1'b1);
    // new first string after close, then ties on length
    push_request(FUNC_FIRST, 8'hFF, 1'b0);
    push_request(FUNC_FIRST, 8'h00, 1'b0);
    push_request(FUNC_FIRST, 8'hFF, 1'b0);
    push_request(FUNC_FIRST, 8'h00, 1'b1);
    push_request(FUNC_SECOND, 8'h00, 1'b0);
    push_request(FUNC_SECOND, 8'hFF, 1'b0);
    push_request(FUNC_SECOND, 8'h00, 1'b0);
    push_request(FUNC_SECOND, 8'hFF, 1'b1);
    // a closing first byte clears a second string in progress
    push_request(FUNC_SECOND, 8'h00, 1'b0);
    push_request(FUNC_FIRST, 8'hAB, 1'b1);
    push_request(FUNC_SECOND, 8'hAB, 1'b1);
    drain_results();

    // Random traffic
    base_items = items_sent;
    base_results = results_due;
    while (items_sent - base_items < ITEM_TARGET ||
           results_due - base_results < RESULT_TARGET) begin
      burst = ($urandom_range(0, 9) < 3);
      for (int i = 0; i < 4; i++) symbols[i] = 8'($urandom_range(0, 255));
      roll = $urandom_range(0, 3);
      alpha = (roll == 3) ? 0 : (1 << roll);
      roll = $urandom_range(0, 99);
      first_text.delete();

      if (!overflow_done && items_sent - base_items > 300) begin
        // overlong second string against a short first string
        overflow_done = 1'b1;
        base = 8'($urandom_range(0, 255));
        first_text = '{base, base ^ 8'h01, base ^ 8'h02};
        send_text(FUNC_FIRST, first_text);
        spot = $urandom_range(990, 1018);
        for (int i = 0; i < MAX_SECOND + 6; i++) begin
          if (i == 5) push_request(FUNC_SECOND, base ^ 8'h02, 1'b0);
          else if (i >= spot && i < spot + 3) push_request(FUNC_SECOND, first_text[i - spot], 1'b0);
          else if (i >= MAX_SECOND + 1 && i < MAX_SECOND + 4)
            push_request(FUNC_SECOND, first_text[i - MAX_SECOND - 1], 1'b0);
          else push_request(FUNC_SECOND, base ^ 8'h80, i == MAX_SECOND + 5);
        end
      end else if (roll < 12) begin
        // loose requests with random kind and end mark
        repeat ($urandom_range(1, 8))
          push_request(logic'($urandom_range(0, 1)), draw_char(), $urandom_range(0, 3) == 0);
      end else begin
        // one first string and a few second strings against it
        roll = $urandom_range(0, 9);
        if (roll < 6) flen = $urandom_range(1, 12);
        else if (roll < 8) flen = $urandom_range(13, 63);
        else if (roll == 8) flen = MAX_FIRST;
        else flen = $urandom_range(MAX_FIRST + 1, MAX_FIRST + 6);
        repeat (flen) first_text.push_back(draw_char());
        send_text(FUNC_FIRST, first_text);
        repeat ($urandom_range(1, 4)) begin
          second_text.delete();
          if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(0, 3)) second_text.push_back(draw_char());
            foreach (first_text[i]) second_text.push_back(first_text[i]);
            repeat ($urandom_range(0, 3)) second_text.push_back(draw_char());
          end else begin
            repeat ($urandom_range(1, 24)) second_text.push_back(draw_char());
          end
          send_text(FUNC_SECOND, second_text);
        end
      end

      if (!midway_done && items_sent - base_items > ITEM_TARGET / 2) begin
        midway_done = 1'b1;
        drain_results();
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d requests and %0d results: directed edge cases, overlong strings",
             items_sent, checked);
    $display("on both sides, ties, copied strings and random spacing between requests.");
    if (failures == 0) begin
      $display("longest_common_substring_unit: match");
    end else begin
      $display("longest_common_substring_unit: mismatch");
    end
    $finish;
  end

endmodule
